### rtl/assert_macros.svh
// Assertion helpers used by the checker file clns_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CLNS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define CLNS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/clns_pkg.sv
`default_nettype none
package clns_pkg;

  localparam int MaxAtoms      = 1024;
  localparam int MaxCells      = 512;
  localparam int NeighborCells = 125;
  localparam int BucketDepth   = 64;
  localparam int MaxNeighbors  = 512;

  localparam int AtomW   = 10;
  localparam int CellW   = 9;
  localparam int SlotW   = 9;
  localparam int CoordW  = 24;
  localparam int CutW    = 48;
  localparam int ValW    = 10;
  localparam int SizeW   = 7;
  localparam int KW      = 7;
  localparam int CntW    = 10;
  localparam int PtrAddrW = 16;
  localparam int MemAddrW = 15;
  localparam int NbAddrW  = 19;
  localparam int CfgIdxW  = 2;

  localparam logic [2:0] ModeAtom   = 3'd0;
  localparam logic [2:0] ModePtr    = 3'd1;
  localparam logic [2:0] ModeMember = 3'd2;
  localparam logic [2:0] ModeSize   = 3'd3;
  localparam logic [2:0] ModeBuild  = 3'd4;
  localparam logic [2:0] ModeRead   = 3'd5;

  localparam logic [CfgIdxW-1:0] CfgCutoff = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBoxX   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBoxY   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgBoxZ   = 2'd3;

  typedef struct packed {
    logic latch;
    logic clr_step;
    logic exec;
    logic rd_home;
    logic home_take;
    logic mod_start;
    logic take_i;
    logic fold_take;
    logic sq_take;
    logic acc;
    logic rd_ptr;
    logic rd_size;
    logic size_take;
    logic rd_mem;
    logic rd_crd;
    logic m_inc;
    logic k_inc;
    logic wr_cnt;
    logic rd_cnt;
    logic rd_nb;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_build;
    logic read_go;
    logic mod_done;
    logic size_zero;
    logic aj_skip;
    logic m_last;
    logic k_last;
  } stat_t;

endpackage
`default_nettype wire

### rtl/cell_list_neighbor_search_top.sv
`default_nettype none
// channel   direction  handshake                 payload
// request   in         in_valid_i / in_ready_o   mode, atom/cell/slot, pos xyz, entry
// result    out        out_valid_o / out_ready_i status, count, overflow, neighbor
// config    in         cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// After reset a clearing pass zeroes the bucket sizes, the neighbor counts and
// the overflow flags; no request is taken meanwhile.
// Loads, reads and rejected requests pass the execute, count-read and
// count-wait states to the result register; a read that hits also reads the
// neighbor list. A build runs the three bit-serial remainder units on the home
// atom, then per neighbor cell reads the pointer and bucket size and, for each
// bucket member above the built atom, runs the units again and tests the cutoff.
// One request is worked at a time; the result register frees the input side,
// so the next request starts while a result waits to be taken.
module cell_list_neighbor_search_top import clns_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         mode_i,
  input  wire logic [AtomW-1:0]   atom_index_i,
  input  wire logic [CellW-1:0]   cell_index_i,
  input  wire logic [SlotW-1:0]   slot_i,
  input  wire logic [CoordW-1:0]  pos_x_i,
  input  wire logic [CoordW-1:0]  pos_y_i,
  input  wire logic [CoordW-1:0]  pos_z_i,
  input  wire logic [ValW-1:0]    entry_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    status_o,
  output logic [CntW-1:0]         neighbor_count_o,
  output logic                    overflow_o,
  output logic [AtomW-1:0]        neighbor_atom_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CutW-1:0]    cfg_data_i
);
  cmd_t  cmd;
  stat_t stat;

  // sequencer: clearing pass, request decode, cell/bucket walk
  clns_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  // stores, minimum-image arithmetic, cutoff test, result register
  clns_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .mode_i, .atom_index_i, .cell_index_i, .slot_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .entry_value_i,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .status_o, .neighbor_count_o, .overflow_o, .neighbor_atom_o
  );
endmodule
`default_nettype wire

### rtl/clns_mod.sv
`default_nettype none
// Restoring remainder x mod len, one quotient bit per cycle.
module clns_mod import clns_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CoordW-1:0] x_i,
  input  wire logic [CoordW-1:0] len_i,
  output logic                   done_o,
  output logic [CoordW-1:0]      rem_o
);
  localparam int CW = $clog2(CoordW);
  localparam logic [CW-1:0] LastStep = CW'(CoordW - 1);

  logic              busy_q;
  logic [CW-1:0]     cnt_q;
  logic [CoordW-1:0] x_q;
  logic [CoordW-1:0] rem_q;
  logic [CoordW:0]   trial;
  logic [CoordW-1:0] rem_d;

  always_comb begin
    trial = {rem_q, x_q[CoordW-1]};
    if (trial >= {1'b0, len_i}) begin
      rem_d = CoordW'(trial - {1'b0, len_i});
    end else begin
      rem_d = trial[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      rem_q <= '0;
    end else if (busy_q) begin
      x_q   <= {x_q[CoordW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = !busy_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

### rtl/clns_datapath.sv
`default_nettype none
module clns_datapath import clns_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  output stat_t                  stat_o,
  input  wire logic [2:0]        mode_i,
  input  wire logic [AtomW-1:0]  atom_index_i,
  input  wire logic [CellW-1:0]  cell_index_i,
  input  wire logic [SlotW-1:0]  slot_i,
  input  wire logic [CoordW-1:0] pos_x_i,
  input  wire logic [CoordW-1:0] pos_y_i,
  input  wire logic [CoordW-1:0] pos_z_i,
  input  wire logic [ValW-1:0]   entry_value_i,
  input  wire logic              cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CutW-1:0]   cfg_data_i,
  output logic                   status_o,
  output logic [CntW-1:0]        neighbor_count_o,
  output logic                   overflow_o,
  output logic [AtomW-1:0]       neighbor_atom_o
);
  // configuration
  logic [CutW-1:0]   cut_q;
  logic [CoordW-1:0] box_x_q, box_y_q, box_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q   <= CutW'(1677721600);
      box_x_q <= CoordW'(409600);
      box_y_q <= CoordW'(409600);
      box_z_q <= CoordW'(409600);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgCutoff: cut_q   <= cfg_data_i;
        CfgBoxX:   box_x_q <= cfg_data_i[CoordW-1:0];
        CfgBoxY:   box_y_q <= cfg_data_i[CoordW-1:0];
        CfgBoxZ:   box_z_q <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // latched request
  logic [2:0]        mode_q;
  logic [AtomW-1:0]  atom_q;
  logic [CellW-1:0]  cell_q;
  logic [SlotW-1:0]  slot_q;
  logic [CoordW-1:0] px_q, py_q, pz_q;
  logic [ValW-1:0]   val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_i;
      atom_q <= atom_index_i;
      cell_q <= cell_index_i;
      slot_q <= slot_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pz_q   <= pos_z_i;
      val_q  <= entry_value_i;
    end
  end

  logic ptr_ok, member_ok, size_ok;
  assign ptr_ok    = (slot_q < SlotW'(NeighborCells)) && (val_q < ValW'(MaxCells));
  assign member_ok = slot_q < SlotW'(BucketDepth);
  assign size_ok   = val_q <= ValW'(BucketDepth);

  // clearing pass counter
  logic [AtomW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // build registers
  logic [CellW-1:0]  home_q;
  logic [CoordW-1:0] cix_q, ciy_q, ciz_q;
  logic [CoordW-1:0] bx_q, by_q, bz_q;
  logic [KW-1:0]     k_q;
  logic [SizeW-1:0]  size_q;
  logic [SizeW-1:0]  m_q;
  logic [CntW-1:0]   nb_cnt_q;
  logic              ovf_q;
  logic [CoordW-1:0] ax_q, ay_q, az_q;
  logic [2*CoordW-1:0] sqx_q, sqy_q, sqz_q;

  // memories and registered read data
  logic [CoordW-1:0] crdx_mem [MaxAtoms];
  logic [CoordW-1:0] crdy_mem [MaxAtoms];
  logic [CoordW-1:0] crdz_mem [MaxAtoms];
  logic [CellW-1:0]  home_mem [MaxAtoms];
  logic [CellW-1:0]  ptr_mem  [MaxCells*NeighborCells];
  logic [AtomW-1:0]  mbr_mem  [MaxCells*BucketDepth];
  logic [SizeW-1:0]  size_mem [MaxCells];
  logic [CntW:0]     cnt_mem  [MaxAtoms];
  logic [AtomW-1:0]  nb_mem   [MaxAtoms*MaxNeighbors];

  logic [CoordW-1:0] crdx_rd, crdy_rd, crdz_rd;
  logic [CellW-1:0]  home_rd, ptr_rd;
  logic [AtomW-1:0]  mbr_rd, nb_rd;
  logic [SizeW-1:0]  size_rd;
  logic [CntW:0]     cnt_rd;

  logic [AtomW-1:0]    crd_ra;
  logic [PtrAddrW-1:0] ptr_wa, ptr_ra;
  logic [CellW-1:0]    size_wa;
  logic [SizeW-1:0]    size_wd;
  logic                size_we;
  logic [AtomW-1:0]    cnt_wa;
  logic [CntW:0]       cnt_wd;
  logic                cnt_we;
  logic                hit;
  logic                nb_we;

  assign crd_ra = cmd_i.rd_crd ? mbr_rd : atom_q;
  assign ptr_wa = PtrAddrW'(cell_q) * PtrAddrW'(NeighborCells) + PtrAddrW'(slot_q);
  assign ptr_ra = PtrAddrW'(home_q) * PtrAddrW'(NeighborCells) + PtrAddrW'(k_q);

  assign size_we = cmd_i.clr_step || (cmd_i.exec && mode_q == ModeSize && size_ok);
  assign size_wa = cmd_i.clr_step ? clr_q[CellW-1:0] : cell_q;
  assign size_wd = cmd_i.clr_step ? '0 : val_q[SizeW-1:0];

  assign cnt_we = cmd_i.clr_step || cmd_i.wr_cnt;
  assign cnt_wa = cmd_i.clr_step ? clr_q : atom_q;
  assign cnt_wd = cmd_i.clr_step ? '0 : {ovf_q, nb_cnt_q};

  assign nb_we = cmd_i.acc && hit && (nb_cnt_q < CntW'(MaxNeighbors));

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mode_q == ModeAtom) begin
      crdx_mem[atom_q] <= px_q;
      crdy_mem[atom_q] <= py_q;
      crdz_mem[atom_q] <= pz_q;
    end
    if (cmd_i.rd_home || cmd_i.rd_crd) begin
      crdx_rd <= crdx_mem[crd_ra];
      crdy_rd <= crdy_mem[crd_ra];
      crdz_rd <= crdz_mem[crd_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mode_q == ModeAtom) begin
      home_mem[atom_q] <= cell_q;
    end
    if (cmd_i.rd_home) begin
      home_rd <= home_mem[atom_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mode_q == ModePtr && ptr_ok) begin
      ptr_mem[ptr_wa] <= val_q[CellW-1:0];
    end
    if (cmd_i.rd_ptr) begin
      ptr_rd <= ptr_mem[ptr_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mode_q == ModeMember && member_ok) begin
      mbr_mem[{cell_q, slot_q[5:0]}] <= val_q;
    end
    if (cmd_i.rd_mem) begin
      mbr_rd <= mbr_mem[{ptr_rd, m_q[5:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (size_we) begin
      size_mem[size_wa] <= size_wd;
    end
    if (cmd_i.rd_size) begin
      size_rd <= size_mem[ptr_rd];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd_i.rd_cnt) begin
      cnt_rd <= cnt_mem[atom_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (nb_we) begin
      nb_mem[{atom_q, nb_cnt_q[8:0]}] <= mbr_rd;
    end
    if (cmd_i.rd_nb) begin
      nb_rd <= nb_mem[{atom_q, slot_q}];
    end
  end

  // per-axis remainder units
  logic done_x, done_y, done_z;
  logic [CoordW-1:0] rem_x, rem_y, rem_z;

  clns_mod u_mod_x (.clk_i, .rst_ni, .start_i(cmd_i.mod_start), .x_i(crdx_rd),
                    .len_i(box_x_q), .done_o(done_x), .rem_o(rem_x));
  clns_mod u_mod_y (.clk_i, .rst_ni, .start_i(cmd_i.mod_start), .x_i(crdy_rd),
                    .len_i(box_y_q), .done_o(done_y), .rem_o(rem_y));
  clns_mod u_mod_z (.clk_i, .rst_ni, .start_i(cmd_i.mod_start), .x_i(crdz_rd),
                    .len_i(box_z_q), .done_o(done_z), .rem_o(rem_z));

  // Minimum image from the two remainders: e = a - b, then one step of L
  // brings it into [-L/2, L/2); the magnitude is returned. A zero box keeps the raw difference.
  function automatic logic [CoordW-1:0] fold_abs(
    input logic [CoordW-1:0] a, input logic [CoordW-1:0] b,
    input logic [CoordW-1:0] len, input logic [CoordW-1:0] cj,
    input logic [CoordW-1:0] ci);
    logic signed [CoordW:0]   e;
    logic signed [CoordW+1:0] e2;
    logic signed [CoordW+1:0] l2;
    logic signed [CoordW:0]   r;
    logic signed [CoordW:0]   ls;
    ls = $signed({1'b0, len});
    l2 = $signed({2'b00, len});
    if (len == '0) begin
      r = $signed({1'b0, cj}) - $signed({1'b0, ci});
    end else begin
      e  = $signed({1'b0, a}) - $signed({1'b0, b});
      e2 = {e, 1'b0};
      if (e2 >= l2) begin
        r = e - ls;
      end else if (e2 < -l2) begin
        r = e + ls;
      end else begin
        r = e;
      end
    end
    if (r < 0) begin
      r = -r;
    end
    return r[CoordW-1:0];
  endfunction

  logic [2*CoordW+1:0] dist2;
  assign dist2 = (2*CoordW+2)'(sqx_q) + (2*CoordW+2)'(sqy_q) + (2*CoordW+2)'(sqz_q);
  assign hit   = dist2 < (2*CoordW+2)'(cut_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.home_take) begin
      home_q   <= home_rd;
      cix_q    <= crdx_rd;
      ciy_q    <= crdy_rd;
      ciz_q    <= crdz_rd;
      k_q      <= '0;
      nb_cnt_q <= '0;
      ovf_q    <= 1'b0;
    end
    if (cmd_i.take_i) begin
      bx_q <= rem_x;
      by_q <= rem_y;
      bz_q <= rem_z;
    end
    if (cmd_i.k_inc) begin
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.size_take) begin
      size_q <= (size_rd > SizeW'(BucketDepth)) ? SizeW'(BucketDepth) : size_rd;
      m_q    <= '0;
    end
    if (cmd_i.m_inc) begin
      m_q <= m_q + 1'b1;
    end
    if (cmd_i.fold_take) begin
      ax_q <= fold_abs(rem_x, bx_q, box_x_q, crdx_rd, cix_q);
      ay_q <= fold_abs(rem_y, by_q, box_y_q, crdy_rd, ciy_q);
      az_q <= fold_abs(rem_z, bz_q, box_z_q, crdz_rd, ciz_q);
    end
    if (cmd_i.sq_take) begin
      sqx_q <= ax_q * ax_q;
      sqy_q <= ay_q * ay_q;
      sqz_q <= az_q * az_q;
    end
    if (cmd_i.acc && hit) begin
      if (nb_cnt_q < CntW'(MaxNeighbors)) begin
        nb_cnt_q <= nb_cnt_q + 1'b1;
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // status toward the controller
  always_comb begin
    stat_o.clr_last  = clr_q == AtomW'(MaxAtoms - 1);
    stat_o.is_build  = mode_q == ModeBuild;
    stat_o.read_go   = (mode_q == ModeRead) && (CntW'(slot_q) < cnt_rd[CntW-1:0]);
    stat_o.mod_done  = done_x && done_y && done_z;
    stat_o.size_zero = size_rd == '0;
    stat_o.aj_skip   = mbr_rd <= atom_q;
    stat_o.m_last    = (m_q + 1'b1) == size_q;
    stat_o.k_last    = k_q == KW'(NeighborCells - 1);
  end

  // result register
  logic err;
  always_comb begin
    case (mode_q)
      ModeAtom:   err = 1'b0;
      ModePtr:    err = !ptr_ok;
      ModeMember: err = !member_ok;
      ModeSize:   err = !size_ok;
      ModeBuild:  err = 1'b0;
      ModeRead:   err = !stat_o.read_go;
      default:    err = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o         <= err;
      neighbor_count_o <= cnt_rd[CntW-1:0];
      overflow_o       <= cnt_rd[CntW];
      neighbor_atom_o  <= (mode_q == ModeRead && !err) ? nb_rd : '0;
    end
  end
endmodule
`default_nettype wire

### rtl/clns_ctrl.sv
`default_nettype none
module clns_ctrl import clns_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);
  localparam logic [4:0] StClear  = 5'd0;
  localparam logic [4:0] StIdle   = 5'd1;
  localparam logic [4:0] StExec   = 5'd2;
  localparam logic [4:0] StCntRd  = 5'd3;
  localparam logic [4:0] StCntW   = 5'd4;
  localparam logic [4:0] StNbW    = 5'd5;
  localparam logic [4:0] StResp   = 5'd6;
  localparam logic [4:0] StHomeW  = 5'd7;
  localparam logic [4:0] StModI   = 5'd8;
  localparam logic [4:0] StPtr    = 5'd9;
  localparam logic [4:0] StPtrW   = 5'd10;
  localparam logic [4:0] StSizeW  = 5'd11;
  localparam logic [4:0] StMem    = 5'd12;
  localparam logic [4:0] StMemW   = 5'd13;
  localparam logic [4:0] StCrdW   = 5'd14;
  localparam logic [4:0] StModJ   = 5'd15;
  localparam logic [4:0] StSq     = 5'd16;
  localparam logic [4:0] StAcc    = 5'd17;
  localparam logic [4:0] StMNext  = 5'd18;
  localparam logic [4:0] StKNext  = 5'd19;
  localparam logic [4:0] StEnd    = 5'd20;

  logic [4:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        if (stat_i.is_build) begin
          cmd_o.rd_home = 1'b1;
          state_d       = StHomeW;
        end else begin
          state_d = StCntRd;
        end
      end
      StCntRd: begin
        cmd_o.rd_cnt = 1'b1;
        state_d      = StCntW;
      end
      StCntW: begin
        if (stat_i.read_go) begin
          cmd_o.rd_nb = 1'b1;
          state_d     = StNbW;
        end else begin
          state_d = StResp;
        end
      end
      StNbW: state_d = StResp;
      StResp: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      StHomeW: begin
        cmd_o.home_take = 1'b1;
        cmd_o.mod_start = 1'b1;
        state_d         = StModI;
      end
      StModI: begin
        if (stat_i.mod_done) begin
          cmd_o.take_i = 1'b1;
          state_d      = StPtr;
        end
      end
      StPtr: begin
        cmd_o.rd_ptr = 1'b1;
        state_d      = StPtrW;
      end
      StPtrW: begin
        cmd_o.rd_size = 1'b1;
        state_d       = StSizeW;
      end
      StSizeW: begin
        cmd_o.size_take = 1'b1;
        state_d         = stat_i.size_zero ? StKNext : StMem;
      end
      StMem: begin
        cmd_o.rd_mem = 1'b1;
        state_d      = StMemW;
      end
      StMemW: begin
        if (stat_i.aj_skip) begin
          state_d = StMNext;
        end else begin
          cmd_o.rd_crd = 1'b1;
          state_d      = StCrdW;
        end
      end
      StCrdW: begin
        cmd_o.mod_start = 1'b1;
        state_d         = StModJ;
      end
      StModJ: begin
        if (stat_i.mod_done) begin
          cmd_o.fold_take = 1'b1;
          state_d         = StSq;
        end
      end
      StSq: begin
        cmd_o.sq_take = 1'b1;
        state_d       = StAcc;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        state_d   = StMNext;
      end
      StMNext: begin
        if (stat_i.m_last) begin
          state_d = StKNext;
        end else begin
          cmd_o.m_inc = 1'b1;
          state_d     = StMem;
        end
      end
      StKNext: begin
        if (stat_i.k_last) begin
          state_d = StEnd;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = StPtr;
        end
      end
      StEnd: begin
        cmd_o.wr_cnt = 1'b1;
        state_d      = StCntRd;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = ovalid_q;
endmodule
`default_nettype wire

### rtl/clns_checker.sv
`default_nettype none
`include "assert_macros.svh"
module clns_checker import clns_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic              status_o,
  input wire logic [CntW-1:0]   neighbor_count_o,
  input wire logic              overflow_o,
  input wire logic [AtomW-1:0]  neighbor_atom_o
);
  `CLNS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `CLNS_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(neighbor_count_o) && $stable(neighbor_atom_o))
  `CLNS_ASSERT_IMP(a_err_no_nb, clk_i, rst_ni, out_valid_o && status_o, neighbor_atom_o == '0)
  `CLNS_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, out_valid_o, neighbor_count_o <= CntW'(MaxNeighbors))
  `CLNS_ASSERT_IMP(a_ovf_full, clk_i, rst_ni, out_valid_o && overflow_o, neighbor_count_o == CntW'(MaxNeighbors))
endmodule

bind cell_list_neighbor_search_top clns_checker u_chk (.*);
`default_nettype wire
